/* design/npn_pkg.sv */
// ----------------------------------------------------------------------------
// npn_pkg: shared types, constants and functions of the NPN canonicalizer
// Holds the controller/datapath interface structs, the state encoding and
// the permutation stepping logic.
// ----------------------------------------------------------------------------
package npn_pkg;

  localparam int TT_W    = 64;
  localparam int N_W     = 3;
  localparam int SLOTS   = 6;
  localparam int IDX_W   = 3;
  localparam int NEG_W   = 6;
  localparam int PERM_W  = SLOTS * IDX_W;

  // Entry j sits at bits 3j+2..3j, which matches the result field layout.
  typedef logic [SLOTS-1:0][IDX_W-1:0] perm_t;

  localparam perm_t PERM_IDENTITY = {3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic last;
  } sts_t;

  typedef struct packed {
    logic  wrap;
    perm_t p;
  } perm_step_t;

  // Table of 2^n ones in the low bits.
  function automatic logic [TT_W-1:0] table_mask(logic [N_W-1:0] n);
    logic [TT_W-1:0] m;
    m = '0;
    for (int x = 0; x < TT_W; x++) begin
      m[x] = ((7'(x) >> n) == 7'd0);
    end
    return m;
  endfunction

  // Lexicographic successor over the first n entries; entries at n and above
  // are left alone. Wraps (and keeps p) after the last permutation.
  function automatic perm_step_t perm_advance(perm_t p, logic [N_W-1:0] n);
    perm_t            q;
    perm_t            r;
    logic             found;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] pi;
    logic [IDX_W-1:0] pv;
    logic [3:0]       src;
    perm_step_t       res;
    found = 1'b0;
    i     = '0;
    j     = '0;
    pv    = '0;
    pi    = '0;
    for (int k = 1; k < SLOTS; k++) begin
      if ((4'(k) < {1'b0, n}) && (p[k-1] < p[k])) begin
        found = 1'b1;
        i     = 3'(k);
      end
    end
    for (int k = 0; k < SLOTS; k++) begin
      if (3'(k) + 3'd1 == i) begin
        pv = p[k];
        pi = 3'(k);
      end
    end
    for (int k = 0; k < SLOTS; k++) begin
      if (found && (4'(k) < {1'b0, n}) && (3'(k) >= i) && (p[k] > pv)) begin
        j = 3'(k);
      end
    end
    q = p;
    if (found) begin
      q[pi] = p[j];
      q[j]  = pv;
    end
    r = q;
    for (int k = 0; k < SLOTS; k++) begin
      if (found && (3'(k) >= i) && (4'(k) < {1'b0, n})) begin
        src  = {1'b0, n} - 4'd1 + {1'b0, i} - 4'(k);
        r[k] = q[src[IDX_W-1:0]];
      end
    end
    res.wrap = !found;
    res.p    = found ? r : p;
    return res;
  endfunction

endpackage

/* design/npn_ctrl.sv */
// ----------------------------------------------------------------------------
// npn_ctrl: sequencing controller of the NPN canonicalizer
// Accepts a request, runs the search one candidate per cycle until the
// datapath flags the last one, then hands the result to the output register.
// ----------------------------------------------------------------------------
module npn_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  npn_pkg::sts_t sts,
  output npn_pkg::cmd_t cmd
);

  npn_pkg::state_t state;
  npn_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= npn_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      npn_pkg::ST_IDLE: begin
        if (in_valid) state_next = npn_pkg::ST_SEARCH;
      end
      npn_pkg::ST_SEARCH: begin
        if (sts.last) state_next = npn_pkg::ST_HOLD;
      end
      npn_pkg::ST_HOLD: begin
        if (!out_valid || out_ready) state_next = npn_pkg::ST_IDLE;
      end
      default: state_next = npn_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.load    = 1'b0;
    cmd.step    = 1'b0;
    cmd.publish = 1'b0;
    case (state)
      npn_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      npn_pkg::ST_SEARCH: begin
        cmd.step = 1'b1;
      end
      npn_pkg::ST_HOLD: begin
        // The previous result must have left the output register first.
        cmd.publish = !out_valid || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_load_starts_search: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == npn_pkg::ST_SEARCH))
    else $error("accepted request did not start a search");

  a_last_ends_search: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && sts.last) |=> (state == npn_pkg::ST_HOLD))
    else $error("search did not end after the last candidate");

  a_publish_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |=> out_valid)
    else $error("published result not shown as valid");

  a_hold_waits: assert property (@(posedge clk) disable iff (rst)
    (state == npn_pkg::ST_HOLD && out_valid && !out_ready) |=>
      (state == npn_pkg::ST_HOLD))
    else $error("result overwrote one not yet taken");

endmodule

/* design/npn_datapath.sv */
// ----------------------------------------------------------------------------
// npn_datapath: candidate generator and best-table tracker
// Builds one negated and permuted candidate table per cycle, compares both
// output polarities against the best so far, and steps mask and permutation.
// ----------------------------------------------------------------------------
module npn_datapath #(
  parameter int MAX_INPUTS = 6
) (
  input  logic                          clk,
  input  npn_pkg::cmd_t                 cmd,
  output npn_pkg::sts_t                 sts,
  input  logic [npn_pkg::TT_W-1:0]      truth_table,
  input  logic [npn_pkg::N_W-1:0]       num_inputs,
  output logic [npn_pkg::TT_W-1:0]      canonical_table,
  output logic [npn_pkg::PERM_W-1:0]    winning_permutation,
  output logic [npn_pkg::NEG_W-1:0]     winning_input_negation,
  output logic                          output_inverted
);

  localparam logic [npn_pkg::N_W-1:0] N_MAX = npn_pkg::N_W'(MAX_INPUTS);

  logic [npn_pkg::TT_W-1:0]  t;
  logic [npn_pkg::TT_W-1:0]  tmask;
  logic [npn_pkg::N_W-1:0]   n;
  logic [npn_pkg::NEG_W-1:0] mask;
  npn_pkg::perm_t            perm;
  logic [npn_pkg::TT_W-1:0]  best;
  npn_pkg::perm_t            best_perm;
  logic [npn_pkg::NEG_W-1:0] best_neg;
  logic                      best_inv;

  logic [npn_pkg::N_W-1:0]   n_sat;
  logic [npn_pkg::TT_W-1:0]  tmask_new;
  logic [npn_pkg::NEG_W-1:0] max_mask;
  npn_pkg::perm_step_t       adv;
  logic [npn_pkg::TT_W-1:0]  cand_raw;
  logic [npn_pkg::TT_W-1:0]  cand;
  logic [npn_pkg::TT_W-1:0]  cand_inv;
  logic                      plain_lt;
  logic                      take_inv;
  logic [npn_pkg::NEG_W-1:0] xi;

  assign n_sat     = (num_inputs > N_MAX) ? N_MAX : num_inputs;
  assign tmask_new = npn_pkg::table_mask(n_sat);
  assign max_mask  = npn_pkg::NEG_W'((7'd1 << n) - 7'd1);
  assign adv       = npn_pkg::perm_advance(perm, n);
  assign sts.last  = adv.wrap && (mask == max_mask);

  // Output bit y takes the source bit x whose input p[j] carries bit j of y,
  // read through the input negation mask.
  always_comb begin
    cand_raw = '0;
    xi       = '0;
    for (int y = 0; y < npn_pkg::TT_W; y++) begin
      xi = '0;
      for (int k = 0; k < npn_pkg::SLOTS; k++) begin
        if (3'(k) < n) xi[perm[k]] = 1'(y >> k);
      end
      cand_raw[y] = t[xi ^ mask];
    end
  end

  assign cand     = cand_raw & tmask;
  assign cand_inv = ~cand_raw & tmask;
  assign plain_lt = cand < best;
  // The inverted form is checked against whatever the plain form left as best.
  assign take_inv = plain_lt ? (cand_inv < cand) : (cand_inv < best);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n         <= n_sat;
      tmask     <= tmask_new;
      t         <= truth_table & tmask_new;
      best      <= truth_table & tmask_new;
      mask      <= '0;
      perm      <= npn_pkg::PERM_IDENTITY;
      best_perm <= npn_pkg::PERM_IDENTITY;
      best_neg  <= '0;
      best_inv  <= 1'b0;
    end else if (cmd.step) begin
      if (take_inv || plain_lt) begin
        best      <= take_inv ? cand_inv : cand;
        best_perm <= perm;
        best_neg  <= mask;
        best_inv  <= take_inv;
      end
      if (adv.wrap) begin
        perm <= npn_pkg::PERM_IDENTITY;
        mask <= mask + npn_pkg::NEG_W'(1);
      end else begin
        perm <= adv.p;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      canonical_table        <= best;
      winning_permutation    <= best_perm;
      winning_input_negation <= best_neg;
      output_inverted        <= best_inv;
    end
  end

endmodule

/* design/npn_truth_table_canonicalizer.sv */
// ----------------------------------------------------------------------------
// npn_truth_table_canonicalizer: NPN canonical form of a truth table
// Exhaustive search over input negations, input permutations and output
// polarity for single-output functions of up to six inputs.
// ----------------------------------------------------------------------------
// A request carries a truth table and its input count n (counts above
// MAX_INPUTS are clamped). The block tries one negation mask and permutation
// per cycle, comparing both output polarities at once, and so searches every
// negation mask with every permutation of the n inputs between accept and
// result hand-off. The single candidate builder and its compare set that
// rate. One request is processed at a time; a finished result waits in the
// output register while the next request is accepted.
module npn_truth_table_canonicalizer #(
  parameter int MAX_INPUTS = 6
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [npn_pkg::TT_W-1:0]    truth_table,
  input  logic [npn_pkg::N_W-1:0]     num_inputs,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [npn_pkg::TT_W-1:0]    canonical_table,
  output logic [npn_pkg::PERM_W-1:0]  winning_permutation,
  output logic [npn_pkg::NEG_W-1:0]   winning_input_negation,
  output logic                        output_inverted
);

  npn_pkg::cmd_t cmd;
  npn_pkg::sts_t sts;

  npn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  npn_datapath #(
    .MAX_INPUTS (MAX_INPUTS)
  ) u_datapath (
    .clk                    (clk),
    .cmd                    (cmd),
    .sts                    (sts),
    .truth_table            (truth_table),
    .num_inputs             (num_inputs),
    .canonical_table        (canonical_table),
    .winning_permutation    (winning_permutation),
    .winning_input_negation (winning_input_negation),
    .output_inverted        (output_inverted)
  );

endmodule

/* tb/sv/npn_canon_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// npn_canon_checker: result checker for the NPN canonicalizer
// Watches the request and result channels. For every accepted request it
// works out the canonical form by exhaustive search. It then compares each
// accepted result, field by field, with the oldest outstanding form.
// ----------------------------------------------------------------------------
module npn_canon_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [npn_pkg::TT_W-1:0]      truth_table,
  input  logic [npn_pkg::N_W-1:0]       num_inputs,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [npn_pkg::TT_W-1:0]      canonical_table,
  input  logic [npn_pkg::PERM_W-1:0]    winning_permutation,
  input  logic [npn_pkg::NEG_W-1:0]     winning_input_negation,
  input  logic                          output_inverted,
  output int                            mismatches,
  output int                            pending,
  output int                            checked
);

  localparam int MAX_PERMS = 720;
  localparam int MAX_ROWS  = 64;
  localparam int MAX_N     = 6;

  typedef struct packed {
    logic [npn_pkg::TT_W-1:0]  canon;
    npn_pkg::perm_t            perm;
    logic [npn_pkg::NEG_W-1:0] neg;
    logic                      inv;
  } npn_form_t;

  npn_form_t      forms_q[$];
  npn_pkg::perm_t perm_list [MAX_PERMS];
  logic [5:0]     row_dest  [MAX_PERMS][MAX_ROWS];
  int             fail_count  = 0;
  int             form_count  = 0;
  int             check_count = 0;

  assign mismatches = fail_count;
  assign pending    = form_count;
  assign checked    = check_count;

  // Exhaustive NPN search in the block's order: negation mask outermost,
  // then permutations in lexicographic order, then plain before inverted.
  function automatic npn_form_t canonical_form(logic [63:0] tt, logic [2:0] n_raw);
    int          n;
    int          size;
    int          nperm;
    int          i;
    int          k;
    int          lo;
    int          hi;
    int          tmp;
    int          order [6];
    bit          more;
    logic [63:0] valid_bits;
    logic [63:0] src;
    logic [63:0] cand;
    logic [63:0] candn;
    npn_form_t   best;
    n          = (n_raw > 3'(MAX_N)) ? MAX_N : int'(n_raw);
    size       = 1 << n;
    valid_bits = (n == MAX_N) ? '1 : ((64'd1 << size) - 64'd1);
    src        = tt & valid_bits;
    for (int j = 0; j < 6; j++) order[j] = j;

    // List every permutation once, with the row each source row lands on.
    nperm = 0;
    more  = 1'b1;
    while (more) begin
      for (int j = 0; j < 6; j++) perm_list[nperm][j] = 3'(order[j]);
      for (int x = 0; x < size; x++) begin
        row_dest[nperm][x] = '0;
        for (int j = 0; j < n; j++) row_dest[nperm][x][j] = x[order[j]];
      end
      nperm++;
      more = 1'b0;
      if (n >= 2) begin
        i = n - 1;
        while (i > 0 && order[i-1] >= order[i]) i--;
        if (i > 0) begin
          k = n - 1;
          while (order[k] <= order[i-1]) k--;
          tmp = order[i-1]; order[i-1] = order[k]; order[k] = tmp;
          lo = i;
          hi = n - 1;
          while (lo < hi) begin
            tmp = order[lo]; order[lo] = order[hi]; order[hi] = tmp;
            lo++;
            hi--;
          end
          more = 1'b1;
        end
      end
    end

    best.canon = src;
    best.perm  = npn_pkg::PERM_IDENTITY;
    best.neg   = '0;
    best.inv   = 1'b0;
    for (int m = 0; m < size; m++) begin
      for (int p = 0; p < nperm; p++) begin
        cand = '0;
        for (int x = 0; x < size; x++) cand[row_dest[p][x]] = src[x ^ m];
        // Only a strictly smaller table wins, so ties keep the earliest form.
        if (cand < best.canon) begin
          best.canon = cand;
          best.perm  = perm_list[p];
          best.neg   = 6'(m);
          best.inv   = 1'b0;
        end
        candn = ~cand & valid_bits;
        if (candn < best.canon) begin
          best.canon = candn;
          best.perm  = perm_list[p];
          best.neg   = 6'(m);
          best.inv   = 1'b1;
        end
      end
    end
    return best;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    if (fail_count < 20) begin
      $display("[%0t] npn check failed: %s got %h expected %h", $time, what, got, want);
    end
    fail_count++;
  endtask

  always @(posedge clk) begin
    npn_form_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        check_count++;
        if (forms_q.size() == 0) begin
          report("result with no request outstanding", canonical_table, '0);
        end else begin
          want = forms_q.pop_front();
          if (canonical_table !== want.canon) begin
            report("canonical_table", canonical_table, want.canon);
          end
          if (winning_permutation !== want.perm) begin
            report("winning_permutation", 64'(winning_permutation), 64'(want.perm));
          end
          if (winning_input_negation !== want.neg) begin
            report("winning_input_negation", 64'(winning_input_negation), 64'(want.neg));
          end
          if (output_inverted !== want.inv) begin
            report("output_inverted", 64'(output_inverted), 64'(want.inv));
          end
        end
      end
      if (in_valid && in_ready) begin
        forms_q.insert(forms_q.size(), canonical_form(truth_table, num_inputs));
      end
      form_count = forms_q.size();
    end
  end

endmodule

/* tb/sv/npn_truth_table_canonicalizer_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// npn_truth_table_canonicalizer_tb: top of the NPN canonicalizer testbench
// Drives directed and random requests over every input count, including
// counts above six, under several idling mixes and one long output hold.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module npn_truth_table_canonicalizer_tb;

  // The run time is dominated by the six-input searches.
  localparam int LIMIT_CYCLES = 1_500_000;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 50;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          in_valid;
  logic                          in_ready;
  logic [npn_pkg::TT_W-1:0]      truth_table;
  logic [npn_pkg::N_W-1:0]       num_inputs;
  logic                          out_valid;
  logic                          out_ready;
  logic [npn_pkg::TT_W-1:0]      canonical_table;
  logic [npn_pkg::PERM_W-1:0]    winning_permutation;
  logic [npn_pkg::NEG_W-1:0]     winning_input_negation;
  logic                          output_inverted;

  int mismatches;
  int pending;
  int checked;
  int cycles    = 0;
  int idle_pct  = 0;
  int stall_pct = 0;
  int hold_req  = 0;
  int sent      = 0;
  int big_sent  = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  npn_truth_table_canonicalizer dut (
    .clk                    (clk),
    .rst                    (rst),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .truth_table            (truth_table),
    .num_inputs             (num_inputs),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .canonical_table        (canonical_table),
    .winning_permutation    (winning_permutation),
    .winning_input_negation (winning_input_negation),
    .output_inverted        (output_inverted)
  );

  npn_canon_checker u_checker (
    .clk                    (clk),
    .rst                    (rst),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .truth_table            (truth_table),
    .num_inputs             (num_inputs),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .canonical_table        (canonical_table),
    .winning_permutation    (winning_permutation),
    .winning_input_negation (winning_input_negation),
    .output_inverted        (output_inverted),
    .mismatches             (mismatches),
    .pending                (pending),
    .checked                (checked)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold each time one is requested.
  initial begin : receiver
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES - 1;
        out_ready = 1'b0;
      end else begin
        out_ready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_request(logic [63:0] tt, logic [2:0] n);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid    = 1'b1;
    truth_table = tt;
    num_inputs  = n;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    if (n >= 3'd6) big_sent++;
  endtask

  initial begin : stimulus
    logic [63:0] tt;
    logic [2:0]  n;
    int          sel;
    int          big_left;
    rst         = 1'b1;
    in_valid    = 1'b0;
    truth_table = '0;
    num_inputs  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Zero inputs: a set table bit is beaten by its inverted form.
    send_request(64'h0, 3'd0);
    send_request(64'h1, 3'd0);
    send_request(64'hFFFF_FFFF_FFFF_FFFE, 3'd0);
    send_request(64'h2, 3'd1);
    send_request(64'h1, 3'd1);
    send_request(64'h3, 3'd1);
    send_request(64'hAAAA_AAAA_AAAA_AAA4, 3'd1);
    send_request(64'h8, 3'd2);
    send_request(64'h6, 3'd2);
    send_request(64'h7, 3'd2);
    send_request(64'hE8, 3'd3);
    send_request(64'h96, 3'd3);
    send_request(64'hFFFF_FFFF_FFFF_FF01, 3'd3);
    send_request(64'h8000, 3'd4);
    send_request(64'h6996, 3'd4);
    send_request(64'h5555_5555_5555_0001, 3'd4);
    send_request(64'h0000_0000_8000_0000, 3'd5);
    send_request({$urandom, $urandom}, 3'd5);
    send_request(64'hFFFF_FFFF_FFFF_FFFF, 3'd6);
    send_request({$urandom, $urandom}, 3'd6);
    // An input count of seven is clamped to six.
    send_request({$urandom, $urandom}, 3'd7);

    big_left = 2;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 71; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 71; end
        default: begin idle_pct = 36; stall_pct = 36; end
      endcase
      // Close the result side for a long stretch so the block backs up.
      if (phase == 0) hold_req++;
      for (int k = 0; k < 25; k++) begin
        sel = $urandom_range(99);
        if (phase == 0 && k < 8) begin
          n = 3'($urandom_range(2));
        end else if (sel < 2 && big_left > 0) begin
          n = 3'(6 + $urandom_range(1));
          big_left--;
        end else if (sel < 12) begin
          n = 3'd5;
        end else begin
          n = 3'($urandom_range(4));
        end
        case ($urandom_range(7))
          0: tt = 64'd1 << $urandom_range(63);
          1: tt = ~(64'd1 << $urandom_range(63));
          2: tt = '1;
          3: tt = '0;
          default: tt = {$urandom, $urandom};
        endcase
        send_request(tt, n);
      end
    end
    @(negedge clk);
    in_valid = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d requests with input counts 0 to 7, %0d of them full six-input searches,",
             sent, big_sent);
    $display("under four idling mixes and one long result hold; %0d results compared.",
             checked);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
